### hdl/lavm_pkg.sv
// Shared types and constants for the look-at view matrix core.
package lavm_pkg;

    // Input item: eye, target and up hint, signed fixed point.
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_in;

    // Result item: one matrix row.
    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col_zero;
        logic signed [31:0] col_one;
        logic signed [31:0] col_two;
        logic signed [31:0] translation;
        logic               degenerate;
        logic               last_row;
    } t_out;

    // Three 32-bit components, index 0 is x.
    typedef logic [2:0][31:0] t_vec3;
    // Three 64-bit two's complement components, index 0 is x.
    typedef logic [2:0][63:0] t_wide3;

    // Sideband carried alongside a vector being normalised.
    typedef struct packed {
        t_vec3 eye;
        t_vec3 up;
        t_vec3 row2;
        logic  ok2;
    } t_side;

    // Everything known about an item after both normalisations.
    typedef struct packed {
        t_vec3       eye;
        t_vec3       row0;
        t_vec3       row1;
        t_vec3       row2;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [31:0] t2;
        logic        ok0;
        logic        ok2;
    } t_frame;

    // Row codes.
    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_BACK = 2'd2;

    // 1.0 in Q2.30.
    localparam logic [31:0] UNIT_ONE = 32'h4000_0000;
    // Half an LSB after a 30-bit right shift.
    localparam logic [63:0] HALF_UNIT = 64'h0000_0000_2000_0000;
    // Saturation limits of the translation.
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

### hdl/lavm_norm.sv
// Pipelined vector normaliser: alignment shift, floor square root, three dividers.
module lavm_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  lavm_pkg::t_wide3 i_vec,
    input  lavm_pkg::t_side  i_side,
    output logic            o_valid,
    output lavm_pkg::t_vec3  o_unit,
    output logic            o_ok,
    output lavm_pkg::t_side  o_side
);
    import lavm_pkg::*;

    // stage map
    localparam int SQ_STG   = 7;
    localparam int SUM_STG  = 8;
    localparam int RT_FIRST = 9;
    localparam int RT_LAST  = 40;
    localparam int PREP_STG = 41;
    localparam int DV_FIRST = 42;
    localparam int DV_LAST  = 72;
    localparam int OUT_STG  = 73;

    logic        r_v    [0:OUT_STG];
    t_side       r_side [0:OUT_STG];
    logic        r_ok   [0:OUT_STG];
    logic [2:0]  r_neg  [0:OUT_STG];

    t_wide3           r_m    [0:6];
    logic [2:0][30:0] r_ms   [SQ_STG:RT_LAST];
    logic [2:0][61:0] r_sq;
    logic [33:0]      r_rem  [SUM_STG:RT_LAST];
    logic [31:0]      r_root [SUM_STG:RT_LAST];
    logic [63:0]      r_src  [SUM_STG:RT_LAST];
    logic [31:0]      r_len  [PREP_STG:DV_LAST];
    logic [2:0][31:0] r_drem [PREP_STG:DV_LAST];
    logic [2:0][30:0] r_dq   [PREP_STG:DV_LAST];
    t_vec3            r_unit;

    t_wide3     w_mag;
    logic [2:0] w_neg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_neg[i] = i_vec[i][63];
            w_mag[i] = w_neg[i] ? -i_vec[i] : i_vec[i];
        end
    end

    // valid, sign and sideband chain
    genvar s;
    generate
        for (s = 0; s <= OUT_STG; s++) begin : g_ctl
            if (s == 0) begin : g_head
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[0] <= 1'b0;
                    end else if (i_adv) begin
                        r_v[0] <= i_valid;
                    end
                end
                always_ff @(posedge i_clk) begin
                    if (i_adv) begin
                        r_side[0] <= i_side;
                        r_neg[0]  <= w_neg;
                        r_ok[0]   <= |(w_mag[0] | w_mag[1] | w_mag[2]);
                        r_m[0]    <= w_mag;
                    end
                end
            end else begin : g_body
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[s] <= 1'b0;
                    end else if (i_adv) begin
                        r_v[s] <= r_v[s-1];
                    end
                end
                always_ff @(posedge i_clk) begin
                    if (i_adv) begin
                        r_side[s] <= r_side[s-1];
                        r_neg[s]  <= r_neg[s-1];
                        r_ok[s]   <= r_ok[s-1];
                    end
                end
            end
        end
    endgenerate

    // align so the largest magnitude tops out at bit 63; bits 63:33 then
    // give the magnitudes with the largest in [2^30, 2^31)
    generate
        for (s = 1; s <= 6; s++) begin : g_shf
            localparam int W = 64 >> s;
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    for (int i = 0; i < 3; i++) begin
                        if ((r_m[s-1][0][63 -: W] | r_m[s-1][1][63 -: W]
                             | r_m[s-1][2][63 -: W]) == '0) begin
                            r_m[s][i] <= r_m[s-1][i] << W;
                        end else begin
                            r_m[s][i] <= r_m[s-1][i];
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_ms[SQ_STG][i] <= r_m[6][i][63:33];
                r_sq[i]         <= r_m[6][i][63:33] * r_m[6][i][63:33];
            end
            r_ms[SUM_STG]   <= r_ms[SQ_STG];
            r_src[SUM_STG]  <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
            r_rem[SUM_STG]  <= '0;
            r_root[SUM_STG] <= '0;
        end
    end

    // floor square root, one result bit per stage
    generate
        for (s = RT_FIRST; s <= RT_LAST; s++) begin : g_rt
            logic [35:0] w_cur;
            logic [35:0] w_try;
            logic        w_ge;
            assign w_cur = {r_rem[s-1], r_src[s-1][63:62]};
            assign w_try = {2'b00, r_root[s-1], 2'b01};
            assign w_ge  = (w_cur >= w_try);
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[s]  <= w_ge ? 34'(w_cur - w_try) : w_cur[33:0];
                    r_root[s] <= {r_root[s-1][30:0], w_ge};
                    r_src[s]  <= {r_src[s-1][61:0], 2'b00};
                    r_ms[s]   <= r_ms[s-1];
                end
            end
        end
    endgenerate

    // dividend m * 2^30 + len / 2 for the rounded quotient
    logic [2:0][61:0] w_num;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {1'b0, r_ms[RT_LAST][i], 30'b0}
                     + {31'b0, r_root[RT_LAST][31:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_len[PREP_STG] <= r_root[RT_LAST];
            for (int i = 0; i < 3; i++) begin
                r_drem[PREP_STG][i] <= {1'b0, w_num[i][61:31]};
                r_dq[PREP_STG][i]   <= w_num[i][30:0];
            end
        end
    end

    // restoring division, one quotient bit per stage; quotient bits shift
    // in as dividend bits shift out
    generate
        for (s = DV_FIRST; s <= DV_LAST; s++) begin : g_dv
            logic [2:0][32:0] w_dc;
            logic [2:0]       w_ge;
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    w_dc[i] = {r_drem[s-1][i], r_dq[s-1][i][30]};
                    w_ge[i] = (w_dc[i] >= {1'b0, r_len[s-1]});
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_len[s] <= r_len[s-1];
                    for (int i = 0; i < 3; i++) begin
                        r_drem[s][i] <= w_ge[i] ? 32'(w_dc[i] - {1'b0, r_len[s-1]})
                                                : w_dc[i][31:0];
                        r_dq[s][i]   <= {r_dq[s-1][i][29:0], w_ge[i]};
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                if (!r_ok[DV_LAST]) begin
                    r_unit[i] <= '0;
                end else if (r_neg[DV_LAST][i]) begin
                    r_unit[i] <= -{1'b0, r_dq[DV_LAST][i]};
                end else begin
                    r_unit[i] <= {1'b0, r_dq[DV_LAST][i]};
                end
            end
        end
    end

    assign o_valid = r_v[OUT_STG];
    assign o_unit  = r_unit;
    assign o_ok    = r_ok[OUT_STG];
    assign o_side  = r_side[OUT_STG];

endmodule

### hdl/look_at_view_matrix_core.sv
// Look-at view matrix core: top level with cross products, translations and row output.
//
// Takes eye, target and up (signed fixed point, any fraction width: the
// translation comes out in the input format) and returns three row items,
// side (row 0), true up (row 1) and backward (row 2), in that order; the
// last carries last_row. Rotation entries are Q2.30, translations saturate
// to 32 bits. If eye equals target every row is zero and flagged
// degenerate; if up is zero or parallel to the view direction rows 0 and 1
// are zero and flagged, row 2 is still valid. The fixed fourth matrix row
// is not sent. Timing: a fully pipelined datapath, one item may enter per
// cycle while the output is free; an item's three rows leave in order as
// the output takes them. As the single result port carries three rows per
// item, a finished item waits while the buffer sends the rows of the one
// before. Most of the latency sits in two normalisers (74 stages each:
// alignment shift, bit-per-stage square root, bit-per-stage division),
// then six stages for row 1 and the translations. An output stall with a
// full last stage freezes the whole pipeline; nothing is lost or repeated.
module look_at_view_matrix_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lavm_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output lavm_pkg::t_out o_data
);
    import lavm_pkg::*;

    // round half away from zero by 2^30, clamp to +-1.0
    function automatic logic [31:0] f_unit_round(input logic [63:0] x);
        logic [63:0] m;
        logic [34:0] r;
        m = x[63] ? -x : x;
        r = 35'((m + HALF_UNIT) >> 30);
        if (r > {3'b000, UNIT_ONE}) begin
            r = {3'b000, UNIT_ONE};
        end
        return x[63] ? 32'(-r) : r[31:0];
    endfunction

    // translation = sat32(round(-dot / 2^30))
    function automatic logic [31:0] f_trans(input logic [63:0] x);
        logic [63:0] m;
        logic [34:0] r;
        m = x[63] ? -x : x;
        r = 35'((m + HALF_UNIT) >> 30);
        if (x[63]) begin
            return (r > {3'b000, SAT_POS}) ? SAT_POS : r[31:0];
        end
        return (r > {3'b000, SAT_NEG}) ? SAT_NEG : 32'(-r);
    endfunction

    logic w_adv;
    logic w_ob_free;

    // ---- view direction: eye - target, normalised ----
    t_wide3 w_d;
    t_side  w_side_a;

    assign w_d[0] = {{32{i_data.eye_x[31]}}, i_data.eye_x}
                  - {{32{i_data.target_x[31]}}, i_data.target_x};
    assign w_d[1] = {{32{i_data.eye_y[31]}}, i_data.eye_y}
                  - {{32{i_data.target_y[31]}}, i_data.target_y};
    assign w_d[2] = {{32{i_data.eye_z[31]}}, i_data.eye_z}
                  - {{32{i_data.target_z[31]}}, i_data.target_z};

    always_comb begin
        w_side_a      = '0;
        w_side_a.eye  = {i_data.eye_z, i_data.eye_y, i_data.eye_x};
        w_side_a.up   = {i_data.up_z, i_data.up_y, i_data.up_x};
    end

    logic  na_valid;
    t_vec3 na_unit;
    logic  na_ok;
    t_side na_side;

    lavm_norm u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_vec   (w_d),
        .i_side  (w_side_a),
        .o_valid (na_valid),
        .o_unit  (na_unit),
        .o_ok    (na_ok),
        .o_side  (na_side)
    );

    // ---- up x row2, exact ----
    logic               r_x1_v;
    logic signed [63:0] r_x1_p [0:5];
    t_side              r_x1_side;
    t_side              n_x1_side;
    logic               r_x2_v;
    t_wide3             r_x2_c;
    t_side              r_x2_side;

    always_comb begin
        n_x1_side      = na_side;
        n_x1_side.row2 = na_unit;
        n_x1_side.ok2  = na_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_v <= 1'b0;
            r_x2_v <= 1'b0;
        end else if (w_adv) begin
            r_x1_v <= na_valid;
            r_x2_v <= r_x1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x1_p[0] <= $signed(na_side.up[1]) * $signed(na_unit[2]);
            r_x1_p[1] <= $signed(na_side.up[2]) * $signed(na_unit[1]);
            r_x1_p[2] <= $signed(na_side.up[2]) * $signed(na_unit[0]);
            r_x1_p[3] <= $signed(na_side.up[0]) * $signed(na_unit[2]);
            r_x1_p[4] <= $signed(na_side.up[0]) * $signed(na_unit[1]);
            r_x1_p[5] <= $signed(na_side.up[1]) * $signed(na_unit[0]);
            r_x1_side <= n_x1_side;

            r_x2_c[0] <= r_x1_p[0] - r_x1_p[1];
            r_x2_c[1] <= r_x1_p[2] - r_x1_p[3];
            r_x2_c[2] <= r_x1_p[4] - r_x1_p[5];
            r_x2_side <= r_x1_side;
        end
    end

    // ---- side vector: normalised cross product ----
    logic  nb_valid;
    t_vec3 nb_unit;
    logic  nb_ok;
    t_side nb_side;

    lavm_norm u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_x2_v),
        .i_vec   (r_x2_c),
        .i_side  (r_x2_side),
        .o_valid (nb_valid),
        .o_unit  (nb_unit),
        .o_ok    (nb_ok),
        .o_side  (nb_side)
    );

    // ok0 needs ok2 too; a zero view direction already forces a zero cross
    // product, so the side normaliser's flag covers both
    t_frame w_frame;
    always_comb begin
        w_frame      = '0;
        w_frame.eye  = nb_side.eye;
        w_frame.row2 = nb_side.row2;
        w_frame.ok2  = nb_side.ok2;
        w_frame.row0 = nb_unit;
        w_frame.ok0  = nb_ok;
    end

    // ---- row 1 and translations ----
    logic               r_r1_v, r_r2_v, r_r3_v, r_r4_v, r_r5_v, r_r6_v;
    t_frame             r_r1_f, r_r2_f, r_r3_f, r_r4_f, r_r5_f, r_r6_f;
    t_frame             n_r3_f, n_r6_f;
    logic signed [63:0] r_r1_a  [0:5];
    logic signed [63:0] r_r1_e0 [0:2];
    logic signed [63:0] r_r1_e2 [0:2];
    logic signed [63:0] r_r2_d  [0:2];
    logic signed [63:0] r_r2_dot0;
    logic signed [63:0] r_r2_dot2;
    logic signed [63:0] r_r4_e1 [0:2];
    logic signed [63:0] r_r5_dot1;

    // row 1 back to Q2.30; rows 0 and 2 translations
    always_comb begin
        n_r3_f = r_r2_f;
        for (int i = 0; i < 3; i++) begin
            n_r3_f.row1[i] = f_unit_round(r_r2_d[i]);
        end
        n_r3_f.t0 = f_trans(r_r2_dot0);
        n_r3_f.t2 = f_trans(r_r2_dot2);
    end

    // row 1 translation
    always_comb begin
        n_r6_f    = r_r5_f;
        n_r6_f.t1 = f_trans(r_r5_dot1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_v <= 1'b0;
            r_r2_v <= 1'b0;
            r_r3_v <= 1'b0;
            r_r4_v <= 1'b0;
            r_r5_v <= 1'b0;
            r_r6_v <= 1'b0;
        end else if (w_adv) begin
            r_r1_v <= nb_valid;
            r_r2_v <= r_r1_v;
            r_r3_v <= r_r2_v;
            r_r4_v <= r_r3_v;
            r_r5_v <= r_r4_v;
            r_r6_v <= r_r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // products, Q4.60 and eye-scaled
            r_r1_a[0] <= $signed(w_frame.row2[1]) * $signed(w_frame.row0[2]);
            r_r1_a[1] <= $signed(w_frame.row2[2]) * $signed(w_frame.row0[1]);
            r_r1_a[2] <= $signed(w_frame.row2[2]) * $signed(w_frame.row0[0]);
            r_r1_a[3] <= $signed(w_frame.row2[0]) * $signed(w_frame.row0[2]);
            r_r1_a[4] <= $signed(w_frame.row2[0]) * $signed(w_frame.row0[1]);
            r_r1_a[5] <= $signed(w_frame.row2[1]) * $signed(w_frame.row0[0]);
            for (int i = 0; i < 3; i++) begin
                r_r1_e0[i] <= $signed(w_frame.eye[i]) * $signed(w_frame.row0[i]);
                r_r1_e2[i] <= $signed(w_frame.eye[i]) * $signed(w_frame.row2[i]);
            end
            r_r1_f <= w_frame;

            // differences and dot sums
            r_r2_d[0] <= r_r1_a[0] - r_r1_a[1];
            r_r2_d[1] <= r_r1_a[2] - r_r1_a[3];
            r_r2_d[2] <= r_r1_a[4] - r_r1_a[5];
            r_r2_dot0 <= r_r1_e0[0] + r_r1_e0[1] + r_r1_e0[2];
            r_r2_dot2 <= r_r1_e2[0] + r_r1_e2[1] + r_r1_e2[2];
            r_r2_f    <= r_r1_f;

            r_r3_f <= n_r3_f;

            for (int i = 0; i < 3; i++) begin
                r_r4_e1[i] <= $signed(r_r3_f.eye[i]) * $signed(r_r3_f.row1[i]);
            end
            r_r4_f <= r_r3_f;

            r_r5_dot1 <= r_r4_e1[0] + r_r4_e1[1] + r_r4_e1[2];
            r_r5_f    <= r_r4_f;

            r_r6_f <= n_r6_f;
        end
    end

    // ---- output buffer: holds one item's rows, sends them one a cycle while i_ready is high ----
    logic       r_ob_v;
    logic [1:0] r_ob_row;
    t_frame     r_ob_f;

    assign w_ob_free = !r_ob_v || (r_ob_row == ROW_BACK && i_ready);
    // pipeline moves when its last stage is empty or the buffer takes it
    assign w_adv     = !r_r6_v || w_ob_free;
    assign o_ready   = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_v   <= 1'b0;
            r_ob_row <= ROW_SIDE;
        end else if (w_adv && r_r6_v) begin
            r_ob_v   <= 1'b1;
            r_ob_row <= ROW_SIDE;
        end else if (r_ob_v && i_ready) begin
            case (r_ob_row)
                ROW_SIDE: r_ob_row <= ROW_UP;
                ROW_UP:   r_ob_row <= ROW_BACK;
                default: begin
                    r_ob_v   <= 1'b0;
                    r_ob_row <= ROW_SIDE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_r6_v) begin
            r_ob_f <= r_r6_f;
        end
    end

    assign o_valid = r_ob_v;

    always_comb begin
        o_data           = '0;
        o_data.row_index = r_ob_row;
        case (r_ob_row)
            ROW_SIDE: begin
                o_data.col_zero    = r_ob_f.row0[0];
                o_data.col_one     = r_ob_f.row0[1];
                o_data.col_two     = r_ob_f.row0[2];
                o_data.translation = r_ob_f.t0;
                o_data.degenerate  = !r_ob_f.ok0;
            end
            ROW_UP: begin
                o_data.col_zero    = r_ob_f.row1[0];
                o_data.col_one     = r_ob_f.row1[1];
                o_data.col_two     = r_ob_f.row1[2];
                o_data.translation = r_ob_f.t1;
                o_data.degenerate  = !r_ob_f.ok0;
            end
            default: begin
                o_data.col_zero    = r_ob_f.row2[0];
                o_data.col_one     = r_ob_f.row2[1];
                o_data.col_two     = r_ob_f.row2[2];
                o_data.translation = r_ob_f.t2;
                o_data.degenerate  = !r_ob_f.ok2;
                o_data.last_row    = 1'b1;
            end
        endcase
    end

endmodule
